### rtl/bba_pkg.sv
// Shared constants, command and status codes, and engine interface types of the allocator.
package bba_pkg;

   localparam int MAX_ENTRIES = 4096;
   localparam int MAP_BYTES   = MAX_ENTRIES / 8;
   localparam int ADDR_W      = $clog2(MAP_BYTES);
   localparam int BPTR_W      = ADDR_W + 1;
   localparam int NUM_W       = 13;

   localparam logic [NUM_W-1:0] ENTRY_COUNT_RESET = NUM_W'(MAX_ENTRIES);
   localparam logic [NUM_W-1:0] CNT_MAX           = {NUM_W{1'b1}};
   localparam logic [BPTR_W-1:0] MAP_BYTES_V      = BPTR_W'(MAP_BYTES);

   typedef enum logic [2:0] {
      CMD_ALLOCATE = 3'd0,
      CMD_RELEASE  = 3'd1,
      CMD_TEST     = 3'd2,
      CMD_MARK     = 3'd3,
      CMD_RECOUNT  = 3'd4
   } command_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_NO_FREE = 2'd1,
      STATUS_BAD_IDX = 2'd2
   } status_type;

   typedef struct packed {
      logic              start;
      logic [2:0]        command;
      logic [NUM_W-1:0]  entry_number;
      logic [BPTR_W-1:0] lim_bytes;
   } eng_req_type;

   typedef struct packed {
      logic idle;
      logic done;
      logic clearing;
   } eng_status_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [NUM_W-1:0] granted_entry;
      logic             bit_was_set;
      logic [NUM_W-1:0] free_count;
      logic             count_corrected;
   } eng_result_type;

endpackage

### rtl/bba_engine.sv
// Command sequencer around the usage bitmap memory and the free-entry counter.
module bba_engine
   import bba_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  eng_req_type    req,
   input  logic           take,
   output eng_status_type stat,
   output eng_result_type result
);

   typedef enum logic [5:0] {
      ST_CLEAR    = 6'b000001,
      ST_IDLE     = 6'b000010,
      ST_ADDR_RD  = 6'b000100,
      ST_ADDR_MOD = 6'b001000,
      ST_SCAN     = 6'b010000,
      ST_DONE     = 6'b100000
   } state_type;

   function automatic logic [3:0] popcount8(input logic [7:0] v);
      logic [3:0] n;
      n = '0;
      for (int k = 0; k < 8; k++) begin
         n = n + 4'(v[k]);
      end
      return n;
   endfunction

   function automatic logic [2:0] lowest_zero(input logic [7:0] v);
      logic [2:0] p;
      p = '0;
      for (int k = 7; k >= 0; k--) begin
         if (!v[k]) begin
            p = 3'(k);
         end
      end
      return p;
   endfunction

   logic [7:0] bitmap_mem [MAP_BYTES];
   logic [7:0] rd_data_ff;

   state_type          state_ff, state_in;
   logic [ADDR_W-1:0]  clear_ptr_ff, clear_ptr_in;
   logic [2:0]         cmd_ff, cmd_in;
   logic [NUM_W-1:0]   num_ff, num_in;
   logic [BPTR_W-1:0]  lim_ff, lim_in;
   logic [BPTR_W-1:0]  ptr_ff, ptr_in;
   logic               rd_vld_ff, rd_vld_in;
   logic [ADDR_W-1:0]  rd_byte_ff, rd_byte_in;
   logic [NUM_W-1:0]   used_ff, used_in;
   logic [NUM_W-1:0]   counter_ff, counter_in;
   logic [1:0]         status_ff, status_in;
   logic [NUM_W-1:0]   granted_ff, granted_in;
   logic               was_ff, was_in;
   logic               corr_ff, corr_in;

   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [7:0]         wr_data;
   logic [ADDR_W-1:0]  rd_addr;

   logic [NUM_W-1:0]   num_m1;
   logic [ADDR_W-1:0]  num_byte;
   logic [2:0]         num_bit;
   logic [7:0]         num_mask;
   logic [NUM_W-1:0]   req_lim_entries;
   logic [NUM_W-1:0]   lim_entries;
   logic               issue;
   logic [2:0]         free_bit;
   logic               was_bit;
   logic [NUM_W-1:0]   free_val;

   assign num_m1          = num_ff - NUM_W'(1);
   assign num_byte        = num_m1[ADDR_W+2:3];
   assign num_bit         = num_m1[2:0];
   assign num_mask        = 8'(1) << num_bit;
   assign req_lim_entries = NUM_W'({req.lim_bytes, 3'b000});
   assign lim_entries     = NUM_W'({lim_ff, 3'b000});
   assign issue           = ptr_ff < lim_ff;
   assign free_bit        = lowest_zero(rd_data_ff);
   assign was_bit         = rd_data_ff[num_bit];
   assign free_val        = lim_entries - used_ff;

   always_comb begin
      state_in     = state_ff;
      clear_ptr_in = clear_ptr_ff;
      cmd_in       = cmd_ff;
      num_in       = num_ff;
      lim_in       = lim_ff;
      ptr_in       = ptr_ff;
      rd_vld_in    = 1'b0;
      rd_byte_in   = rd_byte_ff;
      used_in      = used_ff;
      counter_in   = counter_ff;
      status_in    = status_ff;
      granted_in   = granted_ff;
      was_in       = was_ff;
      corr_in      = corr_ff;
      wr_en        = 1'b0;
      wr_addr      = num_byte;
      wr_data      = rd_data_ff;
      rd_addr      = num_byte;

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en        = 1'b1;
            wr_addr      = clear_ptr_ff;
            wr_data      = '0;
            clear_ptr_in = clear_ptr_ff + ADDR_W'(1);
            if (clear_ptr_ff == ADDR_W'(MAP_BYTES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req.start) begin
               cmd_in     = req.command;
               num_in     = req.entry_number;
               lim_in     = req.lim_bytes;
               status_in  = STATUS_OK;
               granted_in = '0;
               was_in     = 1'b0;
               corr_in    = 1'b0;
               ptr_in     = '0;
               used_in    = '0;
               unique case (req.command)
                  CMD_ALLOCATE, CMD_RECOUNT: begin
                     state_in = ST_SCAN;
                  end
                  CMD_RELEASE, CMD_TEST, CMD_MARK: begin
                     if (req.entry_number == '0 || req.entry_number > req_lim_entries) begin
                        status_in = STATUS_BAD_IDX;
                        state_in  = ST_DONE;
                     end else begin
                        state_in = ST_ADDR_RD;
                     end
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_ADDR_RD: begin
            state_in = ST_ADDR_MOD;
         end
         ST_ADDR_MOD: begin
            was_in   = was_bit;
            state_in = ST_DONE;
            if (cmd_ff == CMD_RELEASE) begin
               wr_en   = 1'b1;
               wr_data = rd_data_ff & ~num_mask;
               if (counter_ff != CNT_MAX) begin
                  counter_in = counter_ff + NUM_W'(1);
               end
            end else if (cmd_ff == CMD_MARK && !was_bit) begin
               wr_en   = 1'b1;
               wr_data = rd_data_ff | num_mask;
               if (counter_ff != '0) begin
                  counter_in = counter_ff - NUM_W'(1);
               end
            end
         end
         ST_SCAN: begin
            rd_addr    = ptr_ff[ADDR_W-1:0];
            rd_vld_in  = issue;
            rd_byte_in = ptr_ff[ADDR_W-1:0];
            if (issue) begin
               ptr_in = ptr_ff + BPTR_W'(1);
            end
            if (rd_vld_ff) begin
               if (cmd_ff == CMD_ALLOCATE) begin
                  if (rd_data_ff != 8'hFF) begin
                     wr_en      = 1'b1;
                     wr_addr    = rd_byte_ff;
                     wr_data    = rd_data_ff | (8'(1) << free_bit);
                     granted_in = NUM_W'({rd_byte_ff, free_bit}) + NUM_W'(1);
                     if (counter_ff != '0) begin
                        counter_in = counter_ff - NUM_W'(1);
                     end
                     state_in = ST_DONE;
                  end
               end else begin
                  used_in = used_ff + NUM_W'(popcount8(rd_data_ff));
               end
            end else if (!issue) begin
               // The whole active range has been read without a hit or the sum is complete.
               state_in = ST_DONE;
               if (cmd_ff == CMD_ALLOCATE) begin
                  status_in = STATUS_NO_FREE;
               end else begin
                  corr_in    = free_val != counter_ff;
                  counter_in = free_val;
               end
            end
         end
         ST_DONE: begin
            if (take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         bitmap_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= bitmap_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clear_ptr_ff <= '0;
         rd_vld_ff    <= 1'b0;
         counter_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         clear_ptr_ff <= clear_ptr_in;
         rd_vld_ff    <= rd_vld_in;
         counter_ff   <= counter_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      num_ff     <= num_in;
      lim_ff     <= lim_in;
      ptr_ff     <= ptr_in;
      rd_byte_ff <= rd_byte_in;
      used_ff    <= used_in;
      status_ff  <= status_in;
      granted_ff <= granted_in;
      was_ff     <= was_in;
      corr_ff    <= corr_in;
   end

   assign stat.idle     = state_ff == ST_IDLE;
   assign stat.done     = state_ff == ST_DONE;
   assign stat.clearing = state_ff == ST_CLEAR;

   assign result.status          = status_ff;
   assign result.granted_entry   = granted_ff;
   assign result.bit_was_set     = was_ff;
   assign result.free_count      = counter_ff;
   assign result.count_corrected = corr_ff;

endmodule

### rtl/bitmap_block_allocator_core.sv
// Top level of the bitmap allocator: request and response channels, register, response register.
// Release, test and mark read the entry's bitmap byte, which release writes back, and mark too
// when the bit was clear; a bad index or unknown command goes straight to its result, an
// allocate stops at a byte with a clear bit; recount and failed allocates read every active byte.
// One transaction is in work at a time; a new request is taken at the edge after the result
// loads the response register, and a stalled response holds the engine. Reset starts a
// clear of every bitmap byte with req_stall high; register writes are taken during that pass.
module bitmap_block_allocator_core
   import bba_pkg::*;
(
   input  logic             clock,
   input  logic             reset,

   input  logic             req_valid,
   output logic             req_stall,
   input  logic [2:0]       req_command,
   input  logic [NUM_W-1:0] req_entry_number,

   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [1:0]       rsp_status,
   output logic [NUM_W-1:0] rsp_granted_entry,
   output logic             rsp_bit_was_set,
   output logic [NUM_W-1:0] rsp_free_count,
   output logic             rsp_count_corrected,

   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [NUM_W-1:0] csr_entry_count
);

   // Entry count register, always ready. Write it only while the block is idle; not enforced.
   logic [NUM_W-1:0] entry_count_ff, entry_count_in;

   assign csr_ready      = 1'b1;
   assign entry_count_in = (csr_valid && csr_ready) ? csr_entry_count : entry_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= ENTRY_COUNT_RESET;
      end else begin
         entry_count_ff <= entry_count_in;
      end
   end

   // Active range in bytes: the low three bits of the count are dropped and the result is
   // clamped to the size of the bitmap.
   logic [BPTR_W-1:0] count_bytes;
   logic [BPTR_W-1:0] lim_bytes;

   assign count_bytes = entry_count_ff[NUM_W-1:3];
   assign lim_bytes   = (count_bytes > MAP_BYTES_V) ? MAP_BYTES_V : count_bytes;

   // Command engine. A request transaction is taken only while the engine sits idle.
   eng_req_type    eng_req;
   eng_status_type eng_stat;
   eng_result_type eng_res;
   logic           eng_take;
   logic           req_accept;

   assign req_stall    = !eng_stat.idle;
   assign req_accept   = req_valid && !req_stall;

   assign eng_req.start        = req_accept;
   assign eng_req.command      = req_command;
   assign eng_req.entry_number = req_entry_number;
   assign eng_req.lim_bytes    = lim_bytes;

   bba_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .req    (eng_req),
      .take   (eng_take),
      .stat   (eng_stat),
      .result (eng_res)
   );

   // Response register. A finished result moves here when the slot is empty or is being
   // drained in the same cycle, which frees the engine for the next request transaction.
   logic           rsp_valid_ff, rsp_valid_in;
   eng_result_type rsp_ff, rsp_in;

   assign eng_take = eng_stat.done && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      rsp_in = rsp_ff;
      if (eng_take) begin
         rsp_valid_in = 1'b1;
         rsp_in       = eng_res;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_ff.status;
   assign rsp_granted_entry   = rsp_ff.granted_entry;
   assign rsp_bit_was_set     = rsp_ff.bit_was_set;
   assign rsp_free_count      = rsp_ff.free_count;
   assign rsp_count_corrected = rsp_ff.count_corrected;

   // No request may enter while the bitmap is still being cleared.
   a_clear_stalls: assert property (@(posedge clock) disable iff (reset)
      eng_stat.clearing |-> req_stall)
      else $error("request channel open during bitmap clearing pass");

   // An accepted request keeps the engine busy in the following cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> req_stall)
      else $error("engine idle right after accepting a request");

   // A granted entry only comes with a successful status and no recount flag.
   a_grant_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_granted_entry != '0) |->
         (rsp_status == STATUS_OK && !rsp_count_corrected))
      else $error("granted entry reported with a failing status");

endmodule

### dv/tb_top.sv
// Self-checking testbench for the bitmap block allocator core.
module tb_top;
   import bba_pkg::*;

   localparam int CLOCK_PERIOD   = 20;
   localparam int RESET_CYCLES   = 7;
   localparam int TIMEOUT_CYCLES = 4_000_000;
   // Cycles allowed after the last response for the block to settle back to idle.
   localparam int IDLE_GUARD     = 8;
   localparam int RANDOM_PHASES  = 10;
   localparam int PHASE_ITEMS    = 52;
   localparam int HOLD_CYCLES    = 300;
   localparam int OVERCOUNT_RELEASES = 40;

   // Command codes above recount are reserved; the block must answer them with no effect.
   localparam logic [2:0] CMD_RESERVED_FIRST = 3'd5;
   localparam logic [2:0] CMD_RESERVED_LAST  = 3'd7;

   typedef struct {
      status_type       status;
      logic [NUM_W-1:0] granted;
      logic             was_set;
      logic [NUM_W-1:0] free;
      logic             corrected;
   } alloc_result_type;

   logic             clock = 1'b0;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   logic [2:0]       req_command;
   logic [NUM_W-1:0] req_entry_number;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic [1:0]       rsp_status;
   logic [NUM_W-1:0] rsp_granted_entry;
   logic             rsp_bit_was_set;
   logic [NUM_W-1:0] rsp_free_count;
   logic             rsp_count_corrected;
   logic             csr_valid;
   logic             csr_ready;
   logic [NUM_W-1:0] csr_entry_count;

   // Shadow copy of the allocator state, advanced once per accepted transaction.
   logic [7:0]       usage_map [MAP_BYTES];
   logic [NUM_W-1:0] free_ctr;
   logic [NUM_W-1:0] active_count;

   alloc_result_type pending_results [$];

   // When set, neither side adds random idle cycles or stalls (a hold-off still applies).
   bit          quiet_mode = 1'b0;
   int          hold_request = 0;
   int          stall_left = 0;
   int unsigned mismatches = 0;
   int unsigned results_checked = 0;
   int unsigned no_free_seen = 0;
   int unsigned bad_index_seen = 0;
   int unsigned csr_writes = 0;
   int unsigned cmd_seen [8];

   bitmap_block_allocator_core dut (.*);

   always begin
      #(CLOCK_PERIOD / 2) clock = 1'b1;
      #(CLOCK_PERIOD / 2) clock = 1'b0;
   end

   // Idle lengths: mostly none or short, now and then a long one.
   function automatic int pick_gap();
      int r;
      if (quiet_mode) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Number of active entries after the register's low bits are dropped and the
   // value is capped at the size of the bitmap.
   function automatic int mapped_entries();
      int bytes;
      bytes = int'(active_count) >> 3;
      if (bytes > MAP_BYTES) bytes = MAP_BYTES;
      return bytes * 8;
   endfunction

   // Predicts the response to one command and updates the shadow state.
   function automatic alloc_result_type model_command(logic [2:0] cmd, logic [NUM_W-1:0] num);
      alloc_result_type res;
      int            lim;
      int            used;
      int            n;
      int            i;
      int            j;
      bit            hit;
      lim           = mapped_entries();
      n             = int'(num);
      res.status    = STATUS_OK;
      res.granted   = '0;
      res.was_set   = 1'b0;
      res.corrected = 1'b0;
      case (cmd)
         CMD_ALLOCATE: begin
            // Lowest clear bit wins; the counter floors at zero.
            hit = 1'b0;
            for (i = 0; i < lim / 8 && !hit; i++) begin
               for (j = 0; j < 8 && !hit; j++) begin
                  if (!usage_map[i][j]) begin
                     usage_map[i][j] = 1'b1;
                     res.granted     = NUM_W'(i * 8 + j + 1);
                     if (free_ctr != '0) free_ctr--;
                     hit = 1'b1;
                  end
               end
            end
            if (!hit) res.status = STATUS_NO_FREE;
         end
         CMD_RELEASE, CMD_TEST, CMD_MARK: begin
            if (n == 0 || n > lim) begin
               res.status = STATUS_BAD_IDX;
            end else begin
               i           = (n - 1) >> 3;
               j           = (n - 1) & 7;
               res.was_set = usage_map[i][j];
               if (cmd == CMD_RELEASE) begin
                  // Releasing a clear entry still counts up, up to the ceiling.
                  usage_map[i][j] = 1'b0;
                  if (free_ctr != CNT_MAX) free_ctr++;
               end else if (cmd == CMD_MARK && !res.was_set) begin
                  usage_map[i][j] = 1'b1;
                  if (free_ctr != '0) free_ctr--;
               end
            end
         end
         CMD_RECOUNT: begin
            used = 0;
            for (i = 0; i < lim / 8; i++) used += $countones(usage_map[i]);
            res.corrected = ((lim - used) != int'(free_ctr));
            free_ctr      = NUM_W'(lim - used);
         end
         default: ;
      endcase
      res.free = free_ctr;
      return res;
   endfunction

   function automatic logic [2:0] pick_command();
      int r;
      r = $urandom_range(0, 99);
      if (r < 30) return CMD_ALLOCATE;
      if (r < 55) return CMD_RELEASE;
      if (r < 68) return CMD_TEST;
      if (r < 82) return CMD_MARK;
      if (r < 90) return CMD_RECOUNT;
      return 3'($urandom_range(CMD_RESERVED_FIRST, CMD_RESERVED_LAST));
   endfunction

   // Mostly valid entries; some zero, some just past the end, some anywhere in the field.
   function automatic logic [NUM_W-1:0] pick_entry();
      int r;
      int lim;
      lim = mapped_entries();
      r   = $urandom_range(0, 99);
      if (r < 3) return '0;
      if (r < 9) return NUM_W'($urandom_range(0, 8191));
      if (r < 14) return NUM_W'(lim + $urandom_range(1, 8));
      if (lim == 0) return NUM_W'($urandom_range(1, 16));
      return NUM_W'($urandom_range(1, lim));
   endfunction

   // Register values: mostly small maps so that scans stay short, with the odd
   // unaligned, zero-sized, full-sized or oversized setting.
   function automatic logic [NUM_W-1:0] pick_count();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return NUM_W'(8 * $urandom_range(1, 8));
      if (r < 70) return NUM_W'($urandom_range(1, 100));
      if (r < 78) return NUM_W'($urandom_range(0, 7));
      if (r < 90) return ENTRY_COUNT_RESET;
      return NUM_W'($urandom_range(0, 8191));
   endfunction

   // Sends one transaction after a random idle stretch and records its prediction
   // at the edge where it is accepted.
   task automatic issue_command(input logic [2:0] cmd, input logic [NUM_W-1:0] num);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid        = 1'b0;
         req_command      = 3'($urandom);
         req_entry_number = NUM_W'($urandom);
         repeat (gap) @(negedge clock);
      end
      req_valid        = 1'b1;
      req_command      = cmd;
      req_entry_number = num;
      do @(posedge clock); while (req_stall !== 1'b0);
      pending_results.push_back(model_command(cmd, num));
      cmd_seen[cmd]++;
   endtask

   // Stops sending and waits until every predicted response has been checked.
   task automatic wait_for_idle();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (IDLE_GUARD) @(posedge clock);
   endtask

   task automatic write_entry_count(input logic [NUM_W-1:0] value);
      @(negedge clock);
      csr_valid       = 1'b1;
      csr_entry_count = value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      active_count = value;
      csr_writes++;
      @(negedge clock);
      csr_valid       = 1'b0;
      csr_entry_count = NUM_W'($urandom);
   endtask

   // Runs with the reset value of the register: counter floor, first and last
   // entries, bad indexes, recount repair, double release and mark, reserved codes.
   task automatic test_after_reset();
      int c;
      issue_command(CMD_ALLOCATE, '0);
      issue_command(CMD_TEST, NUM_W'(1));
      issue_command(CMD_TEST, NUM_W'(MAX_ENTRIES));
      issue_command(CMD_TEST, '0);
      issue_command(CMD_RELEASE, NUM_W'(MAX_ENTRIES + 1));
      issue_command(CMD_MARK, '1);
      issue_command(CMD_RECOUNT, NUM_W'($urandom));
      issue_command(CMD_RELEASE, NUM_W'(1));
      issue_command(CMD_RELEASE, NUM_W'(1));
      issue_command(CMD_MARK, NUM_W'(5));
      issue_command(CMD_MARK, NUM_W'(5));
      for (c = CMD_RESERVED_FIRST; c <= CMD_RESERVED_LAST; c++)
         issue_command(3'(c), NUM_W'($urandom));
      wait_for_idle();
   endtask

   // Zero-sized map, unaligned count rounded down, and a count above the map size.
   task automatic test_count_settings();
      write_entry_count('0);
      issue_command(CMD_ALLOCATE, '0);
      issue_command(CMD_TEST, NUM_W'(1));
      issue_command(CMD_RECOUNT, '0);
      wait_for_idle();
      write_entry_count(NUM_W'(13));
      issue_command(CMD_TEST, NUM_W'(8));
      issue_command(CMD_TEST, NUM_W'(9));
      issue_command(CMD_RECOUNT, '0);
      wait_for_idle();
      write_entry_count('1);
      issue_command(CMD_TEST, NUM_W'(MAX_ENTRIES));
      issue_command(CMD_MARK, NUM_W'(MAX_ENTRIES + 1));
      wait_for_idle();
   endtask

   // Fills an eight-entry map until allocation fails, then frees one and reuses it.
   task automatic test_nothing_free();
      write_entry_count(NUM_W'(8));
      repeat (9) issue_command(CMD_ALLOCATE, '0);
      issue_command(CMD_RELEASE, NUM_W'(3));
      issue_command(CMD_ALLOCATE, '0);
      wait_for_idle();
   endtask

   // Repeated releases of a clear entry push the counter past the size of the map;
   // a recount then brings it back in line with the bitmap.
   task automatic test_release_overcount();
      write_entry_count(ENTRY_COUNT_RESET);
      quiet_mode = 1'b1;
      issue_command(CMD_RECOUNT, '0);
      repeat (OVERCOUNT_RELEASES) issue_command(CMD_RELEASE, NUM_W'(MAX_ENTRIES));
      issue_command(CMD_RECOUNT, '0);
      quiet_mode = 1'b0;
      wait_for_idle();
   endtask

   // The receiver holds off for a long stretch while the sender keeps offering
   // transactions back to back, so the block backs up and stalls its input.
   task automatic test_backpressure();
      write_entry_count(NUM_W'(64));
      quiet_mode   = 1'b1;
      hold_request = HOLD_CYCLES;
      repeat (12) issue_command(pick_command(), pick_entry());
      quiet_mode = 1'b0;
      wait_for_idle();
   endtask

   // Random phases, each under a new register setting; every fourth runs with no idling.
   task automatic test_random_traffic();
      int phase;
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         write_entry_count(pick_count());
         quiet_mode = (phase % 4 == 3);
         repeat (PHASE_ITEMS) issue_command(pick_command(), pick_entry());
         quiet_mode = 1'b0;
         wait_for_idle();
      end
   endtask

   // Receiver: random stalls, plus a long hold-off counted here when requested.
   always @(negedge clock) begin
      if (hold_request > 0) begin
         stall_left   = hold_request;
         hold_request = 0;
      end
      if (stall_left > 0) begin
         rsp_stall = 1'b1;
         stall_left--;
      end else begin
         rsp_stall = 1'b0;
         if ($urandom_range(0, 2) == 0) stall_left = pick_gap();
      end
   end

   function automatic void check_field(string name, logic [NUM_W-1:0] want_v,
                                       logic [NUM_W-1:0] got_v);
      if (got_v !== want_v) begin
         $error("%s mismatch: expected %0d, got %0d", name, want_v, got_v);
         mismatches++;
      end
   endfunction

   // Response checker: every accepted response is matched against the oldest prediction.
   always @(posedge clock) begin
      alloc_result_type want;
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_results.size() == 0) begin
            $error("response transaction with no request outstanding");
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            check_field("status", NUM_W'(want.status), NUM_W'(rsp_status));
            check_field("granted_entry", want.granted, rsp_granted_entry);
            check_field("bit_was_set", NUM_W'(want.was_set), NUM_W'(rsp_bit_was_set));
            check_field("free_count", want.free, rsp_free_count);
            check_field("count_corrected", NUM_W'(want.corrected),
                        NUM_W'(rsp_count_corrected));
            results_checked++;
            if (want.status == STATUS_NO_FREE) no_free_seen++;
            if (want.status == STATUS_BAD_IDX) bad_index_seen++;
         end
      end
   end

   initial begin
      #(CLOCK_PERIOD * TIMEOUT_CYCLES);
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      int unsigned reserved_sent;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_command      = CMD_ALLOCATE;
      req_entry_number = '0;
      csr_valid        = 1'b0;
      csr_entry_count  = ENTRY_COUNT_RESET;
      active_count     = ENTRY_COUNT_RESET;
      free_ctr         = '0;
      reserved_sent    = 0;
      foreach (usage_map[i]) usage_map[i] = '0;
      foreach (cmd_seen[i]) cmd_seen[i] = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_after_reset();
      test_count_settings();
      test_nothing_free();
      test_release_overcount();
      test_backpressure();
      test_random_traffic();

      wait_for_idle();
      if (pending_results.size() != 0) begin
         $error("%0d predicted responses never arrived", pending_results.size());
         mismatches++;
      end
      for (int c = CMD_RESERVED_FIRST; c <= CMD_RESERVED_LAST; c++)
         reserved_sent += cmd_seen[c];
      $display("Sent %0d allocate, %0d release, %0d test, %0d mark, %0d recount and %0d reserved",
               cmd_seen[CMD_ALLOCATE], cmd_seen[CMD_RELEASE], cmd_seen[CMD_TEST],
               cmd_seen[CMD_MARK], cmd_seen[CMD_RECOUNT], reserved_sent);
      $display("Checked %0d responses (%0d no-free, %0d bad-index) over %0d register writes",
               results_checked, no_free_seen, bad_index_seen, csr_writes);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/bba_pkg.sv
rtl/bba_engine.sv
rtl/bitmap_block_allocator_core.sv
dv/tb_top.sv
